// ----- hw/rtl/kptmm_pkg.sv -----
// Shared types and constants for the keyed price table with min/max tracking.
package kptmm_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_OUT_W   = 7;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 104;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  // Probe that walks the cell chain: lookup flags and running aggregates
  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic              hit;
    logic              free;
    logic              any;
    logic [DATA_W-1:0] top_stamp;
    logic [DATA_W-1:0] latest;
    logic [DATA_W-1:0] max_val;
    logic [DATA_W-1:0] min_val;
  } probe_t;

  // Table write request broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [DATA_W-1:0] stamp;
    logic [DATA_W-1:0] value;
  } wr_t;

endpackage

// ----- hw/rtl/kptmm_cell.sv -----
// One table entry of the chain: holds a record, updates the passing probe.
module kptmm_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned CNT_W = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kptmm_pkg::probe_t   probe_i,
  input  logic [IDX_W-1:0]    slot_i,
  input  logic [CNT_W-1:0]    cnt_i,
  output kptmm_pkg::probe_t   probe_o,
  output logic [IDX_W-1:0]    slot_o,
  output logic [CNT_W-1:0]    cnt_o,
  input  kptmm_pkg::wr_t      wr_i,
  input  logic [IDX_W-1:0]    wr_idx_i
);
  import kptmm_pkg::*;

  logic              valid_q;
  logic [DATA_W-1:0] stamp_q;
  logic [DATA_W-1:0] value_q;

  probe_t            probe_d, probe_q;
  logic [IDX_W-1:0]  slot_d, slot_q;
  logic [CNT_W-1:0]  cnt_d, cnt_q;

  logic match;
  logic wr_sel;

  assign match  = valid_q && (stamp_q == probe_i.key);
  assign wr_sel = wr_i.en && (wr_idx_i == IDX_W'(IDX));

  // Probe update: lookup, lowest free entry, aggregates over other entries
  always_comb begin
    probe_d = probe_i;
    slot_d  = slot_i;
    cnt_d   = cnt_i;
    if (match) begin
      probe_d.hit = 1'b1;
      slot_d      = IDX_W'(IDX);
    end else if (!valid_q && !probe_i.free && !probe_i.hit) begin
      probe_d.free = 1'b1;
      slot_d       = IDX_W'(IDX);
    end
    // the probe's own key is folded in at the end of the chain
    if (valid_q && !match) begin
      cnt_d = cnt_i + CNT_W'(1);
      if (!probe_i.any) begin
        probe_d.any       = 1'b1;
        probe_d.top_stamp = stamp_q;
        probe_d.latest    = value_q;
        probe_d.max_val   = value_q;
        probe_d.min_val   = value_q;
      end else begin
        if (stamp_q > probe_i.top_stamp) begin
          probe_d.top_stamp = stamp_q;
          probe_d.latest    = value_q;
        end
        if (value_q > probe_i.max_val) begin
          probe_d.max_val = value_q;
        end
        if (value_q < probe_i.min_val) begin
          probe_d.min_val = value_q;
        end
      end
    end
  end

  // Probe stage, shifts every cycle
  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
    slot_q  <= slot_d;
    cnt_q   <= cnt_d;
  end

  // Entry valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_sel) begin
      valid_q <= 1'b1;
    end
  end

  // Entry record
  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      stamp_q <= wr_i.stamp;
      value_q <= wr_i.value;
    end
  end

  assign probe_o = probe_q;
  assign slot_o  = slot_q;
  assign cnt_o   = cnt_q;

endmodule

// ----- hw/rtl/keyed_price_table_min_max_core.sv -----
// Top level: controller, chain of table cells and result register.
//
// Usage: one update item (stamp, value) enters on the s_axis channel. A probe
// walks a chain of TABLE_DEPTH cells, one cell per cycle; each cell holds one
// table entry. The probe looks up the stamp, finds the lowest free entry and
// gathers latest/max/min/count over the other valid entries. At the end of
// the chain the update's own record is folded in, the table entry is written
// (overwrite on a hit, insert into a free entry, nothing when the table is
// full) and one result item is loaded into the m_axis output register.
// The result passes the register of each cell, the result register and the
// output register. One item is handled at a time: a new item is taken once the
// last one is written back, also while the last result still waits.
// Receiver stall: a finished result waits in the write state until the output
// register is free; the table write happens together with the output load.
// Reset: all entries are marked empty, the output register is emptied and the
// block is ready for an item in the first cycle after reset.
module keyed_price_table_min_max_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // fields from bit 0: stamp[31:0], value[63:32]
  input  logic [kptmm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // fields from bit 0: latest_value[31:0], max_value[63:32],
  // min_value[95:64], dropped[96], entry_count[103:97]
  output logic [kptmm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import kptmm_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

  state_e st_d, st_q;
  logic [IDX_W-1:0] cyc_d, cyc_q;

  probe_t           probe_in;
  probe_t           probe_w [0:TABLE_DEPTH];
  logic [IDX_W-1:0] slot_w  [0:TABLE_DEPTH];
  logic [CNT_W-1:0] cnt_w   [0:TABLE_DEPTH];

  probe_t           res_q;
  logic [IDX_W-1:0] res_slot_q;
  logic [CNT_W-1:0] res_cnt_q;

  logic accept, cap_en, out_load;
  wr_t  wr;

  logic                   take;
  logic [CNT_W-1:0]       cnt_fin;
  logic [DATA_W-1:0]      latest_fin, max_fin, min_fin;

  logic                   m_valid_d, m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Probe launched into the first cell
  always_comb begin
    probe_in       = '0;
    probe_in.key   = s_axis_tdata[DATA_W-1:0];
    probe_in.value = s_axis_tdata[2*DATA_W-1:DATA_W];
  end

  assign probe_w[0] = probe_in;
  assign slot_w[0]  = '0;
  assign cnt_w[0]   = '0;

  // Cell chain
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    kptmm_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .probe_i  (probe_w[g]),
      .slot_i   (slot_w[g]),
      .cnt_i    (cnt_w[g]),
      .probe_o  (probe_w[g+1]),
      .slot_o   (slot_w[g+1]),
      .cnt_o    (cnt_w[g+1]),
      .wr_i     (wr),
      .wr_idx_i (res_slot_q)
    );
  end

  // Next state
  always_comb begin
    st_d  = st_q;
    cyc_d = cyc_q;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          st_d  = ST_SCAN;
          cyc_d = '0;
        end
      end
      ST_SCAN: begin
        if (cyc_q == LAST) begin
          st_d = ST_WRITE;
        end else begin
          cyc_d = cyc_q + IDX_W'(1);
        end
      end
      ST_WRITE: begin
        if (!m_valid_q || m_axis_tready) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    s_axis_tready = (st_q == ST_IDLE);
    cap_en        = (st_q == ST_SCAN) && (cyc_q == LAST);
    out_load      = (st_q == ST_WRITE) && (!m_valid_q || m_axis_tready);
    wr.en         = out_load && (res_q.hit || res_q.free);
    wr.stamp      = res_q.key;
    wr.value      = res_q.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cyc_q <= '0;
    end else begin
      st_q  <= st_d;
      cyc_q <= cyc_d;
    end
  end

  // Capture the probe leaving the last cell
  always_ff @(posedge clk_i) begin
    if (cap_en) begin
      res_q      <= probe_w[TABLE_DEPTH];
      res_slot_q <= slot_w[TABLE_DEPTH];
      res_cnt_q  <= cnt_w[TABLE_DEPTH];
    end
  end

  // Fold the update's own record into the aggregates
  always_comb begin
    take       = res_q.hit || res_q.free;
    cnt_fin    = res_cnt_q + CNT_W'(take);
    latest_fin = res_q.latest;
    max_fin    = res_q.max_val;
    min_fin    = res_q.min_val;
    if (take) begin
      if (!res_q.any) begin
        latest_fin = res_q.value;
        max_fin    = res_q.value;
        min_fin    = res_q.value;
      end else begin
        if (res_q.key > res_q.top_stamp) begin
          latest_fin = res_q.value;
        end
        if (res_q.value > res_q.max_val) begin
          max_fin = res_q.value;
        end
        if (res_q.value < res_q.min_val) begin
          min_fin = res_q.value;
        end
      end
    end
  end

  // Output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {CNT_OUT_W'(cnt_fin), !take, min_fin, max_fin, latest_fin};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  // an accepted item starts the chain walk from the first cell
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (st_q == ST_SCAN) && (cyc_q == '0))
    else $error("scan did not start after accept");

  // the probe is captured exactly once, then the block writes back
  a_capture_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_en |=> (st_q == ST_WRITE))
    else $error("no write state after capture");

  // a dropped update only happens with every entry in use
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[3*DATA_W]) |->
      (m_axis_tdata[3*DATA_W+1 +: CNT_OUT_W] == CNT_OUT_W'(TABLE_DEPTH)))
    else $error("drop reported with free entries");

  // loading a result always presents it on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("loaded result not presented");
`endif

endmodule

// ----- sim/keyed_price_table_min_max_checker.sv -----
// Checker: mirrors the price table, predicts each result item and compares it.
module keyed_price_table_min_max_checker #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // fields from bit 0: stamp[31:0], value[63:32]
  input  logic [kptmm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // fields from bit 0: latest_value[31:0], max_value[63:32],
  // min_value[95:64], dropped[96], entry_count[103:97]
  input  logic [kptmm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  import kptmm_pkg::*;

  typedef struct {
    logic [DATA_W-1:0]    latest_value;
    logic [DATA_W-1:0]    max_value;
    logic [DATA_W-1:0]    min_value;
    logic                 dropped;
    logic [CNT_OUT_W-1:0] entry_count;
  } price_summary_t;

  // Mirror of the table
  logic              slot_used  [TABLE_DEPTH];
  logic [DATA_W-1:0] slot_stamp [TABLE_DEPTH];
  logic [DATA_W-1:0] slot_price [TABLE_DEPTH];

  price_summary_t expected_summaries[$];
  int unsigned    fails;

  // Apply one update to the mirror and return the summary it should produce
  function automatic price_summary_t apply_update(input logic [DATA_W-1:0] stamp,
                                                  input logic [DATA_W-1:0] price);
    price_summary_t    sum;
    int                hit_idx;
    int                free_idx;
    int unsigned       live;
    logic [DATA_W-1:0] top_stamp;
    hit_idx  = -1;
    free_idx = -1;
    live     = 0;
    top_stamp = '0;
    sum.latest_value = '0;
    sum.max_value    = '0;
    sum.min_value    = '0;
    sum.dropped      = 1'b0;

    // lookup: first matching stamp, lowest free slot
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_used[i]) begin
        if (hit_idx < 0 && slot_stamp[i] == stamp) hit_idx = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end

    if (hit_idx >= 0) begin
      slot_price[hit_idx] = price;
    end else if (free_idx >= 0) begin
      slot_used[free_idx]  = 1'b1;
      slot_stamp[free_idx] = stamp;
      slot_price[free_idx] = price;
    end else begin
      sum.dropped = 1'b1;
    end

    // aggregate over live entries; first live entry seeds everything
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_used[i]) begin
        if (live == 0) begin
          top_stamp        = slot_stamp[i];
          sum.latest_value = slot_price[i];
          sum.max_value    = slot_price[i];
          sum.min_value    = slot_price[i];
        end else begin
          if (slot_stamp[i] > top_stamp) begin
            top_stamp        = slot_stamp[i];
            sum.latest_value = slot_price[i];
          end
          if (slot_price[i] > sum.max_value) sum.max_value = slot_price[i];
          if (slot_price[i] < sum.min_value) sum.min_value = slot_price[i];
        end
        live++;
      end
    end
    sum.entry_count = live[CNT_OUT_W-1:0];
    return sum;
  endfunction

  // One line per mismatch
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fails++;
  endtask

  // Watch both channels; results are matched before the same edge's update is queued
  always @(posedge clk_i or negedge rst_ni) begin
    price_summary_t got;
    price_summary_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
      expected_summaries.delete();
      fails = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.latest_value = m_axis_tdata[DATA_W-1:0];
        got.max_value    = m_axis_tdata[2*DATA_W-1:DATA_W];
        got.min_value    = m_axis_tdata[3*DATA_W-1:2*DATA_W];
        got.dropped      = m_axis_tdata[3*DATA_W];
        got.entry_count  = m_axis_tdata[3*DATA_W+1 +: CNT_OUT_W];
        if (expected_summaries.size() == 0) begin
          report_mismatch($sformatf("result item with none expected, tdata %h",
                                    m_axis_tdata));
        end else begin
          want = expected_summaries.pop_front();
          if (got.latest_value !== want.latest_value)
            report_mismatch($sformatf("latest_value got %h expected %h",
                                      got.latest_value, want.latest_value));
          if (got.max_value !== want.max_value)
            report_mismatch($sformatf("max_value got %h expected %h",
                                      got.max_value, want.max_value));
          if (got.min_value !== want.min_value)
            report_mismatch($sformatf("min_value got %h expected %h",
                                      got.min_value, want.min_value));
          if (got.dropped !== want.dropped)
            report_mismatch($sformatf("dropped got %b expected %b",
                                      got.dropped, want.dropped));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      got.entry_count, want.entry_count));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_summaries.push_back(apply_update(s_axis_tdata[DATA_W-1:0],
                                                  s_axis_tdata[2*DATA_W-1:DATA_W]));
    end
    fail_count_o <= fails;
    pending_o    <= expected_summaries.size();
  end

endmodule

// ----- sim/keyed_price_table_min_max_core_tb.sv -----
// Testbench top: drives update items and output stalls, gives the verdict.
module keyed_price_table_min_max_core_tb;
  import kptmm_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned N_RANDOM    = 540;
  localparam int unsigned N_CALM      = 60;   // trailing items with no idling

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int unsigned            fail_count;
  int unsigned            pending;
  bit                     calm;
  logic [DATA_W-1:0]      sent_stamps[$];

  keyed_price_table_min_max_core #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  keyed_price_table_min_max_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: alternating calm and stalling stretches, random stall bursts in the stalling ones
  initial begin
    int unsigned stall_left;
    int unsigned phase_left;
    bit          stalling;
    m_axis_tready = 1'b1;
    stall_left = 0;
    stalling   = 1'b1;
    phase_left = $urandom_range(100, 600);
    forever begin
      @(negedge clk_i);
      if (phase_left == 0) begin
        stalling   = ~stalling;
        phase_left = $urandom_range(100, 600);
      end else begin
        phase_left--;
      end
      if (calm) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (stalling && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Price with a bias toward the extremes and small values
  function automatic logic [DATA_W-1:0] pick_price();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // Offer one update item and hold it until accepted, then maybe go idle
  task automatic send_update(input logic [DATA_W-1:0] stamp,
                             input logic [DATA_W-1:0] price);
    int unsigned idle;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {price, stamp};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_stamps.push_back(stamp);
    if (!calm && $urandom_range(0, 2) == 0) begin
      // several short bursts back to back so the next item lands anywhere in the scan
      idle = 0;
      repeat ($urandom_range(1, 12)) idle += $urandom_range(1, 7);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (idle - 1) @(negedge clk_i);
    end
  endtask

  // Stimulus and verdict
  initial begin
    logic [DATA_W-1:0] stamp;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    calm          = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, extremes, overwrites, equal prices
    send_update(32'h0000_0000, 32'h0000_0000);
    send_update(32'hffff_ffff, 32'hffff_ffff);
    send_update(32'h0000_0000, 32'h0000_0007);   // hit, latest unchanged
    send_update(32'hffff_ffff, 32'h0000_0000);   // hit on the latest entry
    send_update(32'h0000_0001, 32'hffff_ffff);
    send_update(32'h0000_0002, 32'hffff_ffff);   // equal maxima
    send_update(32'h8000_0000, 32'h5555_5555);
    send_update(32'h7fff_ffff, 32'haaaa_aaaa);
    send_update(32'h0000_0001, 32'h0000_0003);   // lower one of the maxima
    send_update(32'h0000_0002, 32'h0000_0003);   // max now drops
    send_update(32'hffff_ffff, 32'h0000_0003);   // min leaves the latest entry

    // fill the table with fresh stamps
    for (int i = 6; i < TABLE_DEPTH; i++) begin
      stamp = $urandom_range(16, 32'hfffe_ffff);
      send_update(stamp, pick_price());
    end

    // directed on a full table: drops and hits
    send_update(32'hffff_fffe, 32'h0000_0001);   // new stamp, dropped
    send_update(32'h8000_0000, 32'hffff_ffff);   // hit still allowed
    send_update(32'h0000_0003, 32'h0000_0000);   // dropped, table unchanged
    send_update(32'hffff_ffff, 32'h0000_0009);   // hit on the latest entry

    // random: half reuse sent stamps, the rest fresh or small stamps
    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      calm = (n >= N_RANDOM - N_CALM);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: stamp = sent_stamps[$urandom_range(0, sent_stamps.size() - 1)];
        5, 6, 7:       stamp = $urandom();
        default:       stamp = $urandom_range(0, 15);
      endcase
      send_update(stamp, pick_price());
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TABLE_DEPTH + 8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/kptmm_pkg.sv
hw/rtl/kptmm_cell.sv
hw/rtl/keyed_price_table_min_max_core.sv
sim/keyed_price_table_min_max_checker.sv
sim/keyed_price_table_min_max_core_tb.sv
